/* rtl/core/asbs_pkg.sv */
package asbs_pkg;

    localparam int CP_W       = 21;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 8;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] MODE_SEMI  = 2'd0;
    localparam logic [1:0] MODE_BLOCK = 2'd1;

    localparam logic KIND_SEMI  = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    localparam logic [CP_W-1:0] CH_NUL    = 21'h00;
    localparam logic [CP_W-1:0] CH_TAB    = 21'h09;
    localparam logic [CP_W-1:0] CH_LF     = 21'h0A;
    localparam logic [CP_W-1:0] CH_CR     = 21'h0D;
    localparam logic [CP_W-1:0] CH_SPACE  = 21'h20;
    localparam logic [CP_W-1:0] CH_BANG   = 21'h21;
    localparam logic [CP_W-1:0] CH_DQUOTE = 21'h22;
    localparam logic [CP_W-1:0] CH_PCT    = 21'h25;
    localparam logic [CP_W-1:0] CH_AMP    = 21'h26;
    localparam logic [CP_W-1:0] CH_LPAREN = 21'h28;
    localparam logic [CP_W-1:0] CH_STAR   = 21'h2A;
    localparam logic [CP_W-1:0] CH_PLUS   = 21'h2B;
    localparam logic [CP_W-1:0] CH_COMMA  = 21'h2C;
    localparam logic [CP_W-1:0] CH_MINUS  = 21'h2D;
    localparam logic [CP_W-1:0] CH_DOT    = 21'h2E;
    localparam logic [CP_W-1:0] CH_SLASH  = 21'h2F;
    localparam logic [CP_W-1:0] CH_DIG0   = 21'h30;
    localparam logic [CP_W-1:0] CH_DIG9   = 21'h39;
    localparam logic [CP_W-1:0] CH_COLON  = 21'h3A;
    localparam logic [CP_W-1:0] CH_SEMI   = 21'h3B;
    localparam logic [CP_W-1:0] CH_LT     = 21'h3C;
    localparam logic [CP_W-1:0] CH_EQUAL  = 21'h3D;
    localparam logic [CP_W-1:0] CH_GT     = 21'h3E;
    localparam logic [CP_W-1:0] CH_QUEST  = 21'h3F;
    localparam logic [CP_W-1:0] CH_UP_A   = 21'h41;
    localparam logic [CP_W-1:0] CH_UP_Z   = 21'h5A;
    localparam logic [CP_W-1:0] CH_LBRACK = 21'h5B;
    localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CH_CARET  = 21'h5E;
    localparam logic [CP_W-1:0] CH_USCORE = 21'h5F;
    localparam logic [CP_W-1:0] CH_LO_A   = 21'h61;
    localparam logic [CP_W-1:0] CH_LO_I   = 21'h69;
    localparam logic [CP_W-1:0] CH_LO_N   = 21'h6E;
    localparam logic [CP_W-1:0] CH_LO_S   = 21'h73;
    localparam logic [CP_W-1:0] CH_LO_Z   = 21'h7A;
    localparam logic [CP_W-1:0] CH_LBRACE = 21'h7B;
    localparam logic [CP_W-1:0] CH_PIPE   = 21'h7C;
    localparam logic [CP_W-1:0] CH_RBRACE = 21'h7D;

    typedef enum logic [4:0] {
        CLS_ZERO,
        CLS_RBRACE,
        CLS_LBRACE,
        CLS_NEWLINE,
        CLS_SPACE,
        CLS_SEMI,
        CLS_DQUOTE,
        CLS_BSLASH,
        CLS_SLASH,
        CLS_STAR,
        CLS_PLUS,
        CLS_MINUS,
        CLS_BANG,
        CLS_EQUAL,
        CLS_PUNCT,
        CLS_LET_I,
        CLS_LET_A,
        CLS_LET_N,
        CLS_LET_S,
        CLS_IDENT,
        CLS_OTHER
    } char_class_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_PRE,
        PH_POSTWS,
        PH_SLASH,
        PH_PLUS,
        PH_MINUS,
        PH_BANG,
        PH_I,
        PH_A,
        PH_IN,
        PH_AS,
        PH_BWS,
        PH_BSLASH,
        PH_BLINE,
        PH_BBLOCK,
        PH_BSTAR,
        PH_BDISP,
        PH_BSTR,
        PH_BESC
    } phase_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  mode;
        char_class_t cls;
        logic        range_start;
    } item_t;

    typedef struct packed {
        phase_t phase;
        logic   done;
        logic   found;
    } step_t;

endpackage

/* rtl/core/asbs_front.sv */
module asbs_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [asbs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [asbs_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output asbs_pkg::item_t                push_item
);
    import asbs_pkg::*;

    function automatic char_class_t classify(input logic [CP_W-1:0] c);
        char_class_t r;
        begin
            r = CLS_OTHER;
            priority if (c == CH_NUL)
                r = CLS_ZERO;
            else if (c == CH_RBRACE)
                r = CLS_RBRACE;
            else if (c == CH_LBRACE)
                r = CLS_LBRACE;
            else if (c == CH_LF)
                r = CLS_NEWLINE;
            else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                r = CLS_SPACE;
            else if (c == CH_SEMI)
                r = CLS_SEMI;
            else if (c == CH_DQUOTE)
                r = CLS_DQUOTE;
            else if (c == CH_BSLASH)
                r = CLS_BSLASH;
            else if (c == CH_SLASH)
                r = CLS_SLASH;
            else if (c == CH_STAR)
                r = CLS_STAR;
            else if (c == CH_PLUS)
                r = CLS_PLUS;
            else if (c == CH_MINUS)
                r = CLS_MINUS;
            else if (c == CH_BANG)
                r = CLS_BANG;
            else if (c == CH_EQUAL)
                r = CLS_EQUAL;
            else if (c == CH_COMMA || c == CH_DOT || c == CH_COLON || c == CH_PCT ||
                     c == CH_GT || c == CH_LT || c == CH_LBRACK || c == CH_LPAREN ||
                     c == CH_QUEST || c == CH_CARET || c == CH_PIPE || c == CH_AMP)
                r = CLS_PUNCT;
            else if (c == CH_LO_I)
                r = CLS_LET_I;
            else if (c == CH_LO_A)
                r = CLS_LET_A;
            else if (c == CH_LO_N)
                r = CLS_LET_N;
            else if (c == CH_LO_S)
                r = CLS_LET_S;
            else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                     (c >= CH_DIG0 && c <= CH_DIG9) || c == CH_USCORE)
                r = CLS_IDENT;
            else
                r = CLS_OTHER;
            return r;
        end
    endfunction

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;

    always_comb
    begin
        push_item.start       = s_axis_tuser[0];
        push_item.mode        = s_axis_tuser[2:1];
        push_item.range_start = s_axis_tuser[3];
        push_item.cls         = classify(s_axis_tdata[CP_W-1:0]);
    end

endmodule

/* rtl/core/asbs_queue.sv */
module asbs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  asbs_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output asbs_pkg::item_t pop_item
);
    import asbs_pkg::*;

    item_t             slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_CW-1:0]   count_reg;
    logic [Q_CW-1:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CW'(do_push) - Q_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/asbs_back.sv */
module asbs_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  asbs_pkg::item_t                pop_item,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [asbs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser
);
    import asbs_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    logic   kind_reg;
    logic   kind_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_found_reg;
    logic   out_found_next;
    logic   out_kind_reg;
    logic   out_kind_next;
    logic   take;
    logic   emit;
    logic   emit_found;
    step_t  st;
    phase_t cur;

    function automatic step_t mk(input phase_t p, input logic d, input logic f);
        step_t s;
        begin
            s.phase = p;
            s.done  = d;
            s.found = f;
            return s;
        end
    endfunction

    function automatic step_t bdisp(input char_class_t c);
        step_t s;
        begin
            unique case (c)
                CLS_DQUOTE: s = mk(PH_BSTR, 1'b0, 1'b0);
                CLS_LBRACE: s = mk(PH_IDLE, 1'b1, 1'b0);
                CLS_RBRACE,
                CLS_SEMI,
                CLS_ZERO:   s = mk(PH_IDLE, 1'b1, 1'b1);
                default:    s = mk(PH_BWS, 1'b0, 1'b0);
            endcase
            return s;
        end
    endfunction

    function automatic step_t bws(input char_class_t c);
        step_t s;
        begin
            unique case (c)
                CLS_SPACE,
                CLS_NEWLINE: s = mk(PH_BWS, 1'b0, 1'b0);
                CLS_SLASH:   s = mk(PH_BSLASH, 1'b0, 1'b0);
                default:     s = bdisp(c);
            endcase
            return s;
        end
    endfunction

    function automatic step_t bblock(input char_class_t c);
        step_t s;
        begin
            unique case (c)
                CLS_ZERO: s = bws(c);
                CLS_STAR: s = mk(PH_BSTAR, 1'b0, 1'b0);
                default:  s = mk(PH_BBLOCK, 1'b0, 1'b0);
            endcase
            return s;
        end
    endfunction

    function automatic step_t bstr(input char_class_t c);
        step_t s;
        begin
            unique case (c)
                CLS_ZERO:   s = bdisp(c);
                CLS_BSLASH: s = mk(PH_BESC, 1'b0, 1'b0);
                CLS_DQUOTE: s = mk(PH_BDISP, 1'b0, 1'b0);
                default:    s = mk(PH_BSTR, 1'b0, 1'b0);
            endcase
            return s;
        end
    endfunction

    assign take      = !out_valid_reg || m_axis_tready;
    assign pop_ready = take;

    // Next phase and decision for the item at the head of the queue.
    always_comb
    begin
        cur       = phase_reg;
        kind_next = kind_reg;
        st        = mk(phase_reg, 1'b0, 1'b0);
        if (pop_item.start)
        begin
            kind_next = (pop_item.mode == MODE_BLOCK) ? KIND_BLOCK : KIND_SEMI;
            if (pop_item.mode == MODE_SEMI)
                cur = PH_PRE;
            else if (pop_item.mode == MODE_BLOCK)
                cur = PH_BWS;
            else
                cur = PH_IDLE;
        end
        unique case (cur)
            PH_IDLE:
            begin
                st = mk(PH_IDLE, pop_item.start, 1'b0);
            end
            PH_PRE:
            begin
                if (pop_item.cls == CLS_ZERO || pop_item.cls == CLS_RBRACE ||
                    pop_item.range_start)
                    st = mk(PH_IDLE, 1'b1, 1'b1);
                else if (pop_item.cls == CLS_NEWLINE)
                    st = mk(PH_POSTWS, 1'b0, 1'b0);
                else if (pop_item.cls == CLS_SPACE)
                    st = mk(PH_PRE, 1'b0, 1'b0);
                else
                    st = mk(PH_IDLE, 1'b1, 1'b0);
            end
            PH_POSTWS:
            begin
                unique case (pop_item.cls)
                    CLS_SPACE,
                    CLS_NEWLINE: st = mk(PH_POSTWS, 1'b0, 1'b0);
                    CLS_PUNCT,
                    CLS_SEMI,
                    CLS_STAR,
                    CLS_EQUAL:   st = mk(PH_IDLE, 1'b1, 1'b0);
                    CLS_SLASH:   st = mk(PH_SLASH, 1'b0, 1'b0);
                    CLS_PLUS:    st = mk(PH_PLUS, 1'b0, 1'b0);
                    CLS_MINUS:   st = mk(PH_MINUS, 1'b0, 1'b0);
                    CLS_BANG:    st = mk(PH_BANG, 1'b0, 1'b0);
                    CLS_LET_I:   st = mk(PH_I, 1'b0, 1'b0);
                    CLS_LET_A:   st = mk(PH_A, 1'b0, 1'b0);
                    default:     st = mk(PH_IDLE, 1'b1, 1'b1);
                endcase
            end
            PH_SLASH:
            begin
                st = mk(PH_IDLE, 1'b1,
                        pop_item.cls == CLS_SLASH || pop_item.cls == CLS_STAR);
            end
            PH_PLUS:
            begin
                st = mk(PH_IDLE, 1'b1, pop_item.cls == CLS_PLUS);
            end
            PH_MINUS:
            begin
                st = mk(PH_IDLE, 1'b1, pop_item.cls == CLS_MINUS);
            end
            PH_BANG:
            begin
                st = mk(PH_IDLE, 1'b1, pop_item.cls != CLS_EQUAL);
            end
            PH_I:
            begin
                if (pop_item.cls == CLS_LET_N)
                    st = mk(PH_IN, 1'b0, 1'b0);
                else
                    st = mk(PH_IDLE, 1'b1, 1'b1);
            end
            PH_A:
            begin
                if (pop_item.cls == CLS_LET_S)
                    st = mk(PH_AS, 1'b0, 1'b0);
                else
                    st = mk(PH_IDLE, 1'b1, 1'b1);
            end
            PH_IN,
            PH_AS:
            begin
                st = mk(PH_IDLE, 1'b1,
                        pop_item.cls == CLS_LET_I || pop_item.cls == CLS_LET_A ||
                        pop_item.cls == CLS_LET_N || pop_item.cls == CLS_LET_S ||
                        pop_item.cls == CLS_IDENT);
            end
            PH_BWS:
            begin
                st = bws(pop_item.cls);
            end
            PH_BSLASH:
            begin
                if (pop_item.cls == CLS_SLASH)
                    st = mk(PH_BLINE, 1'b0, 1'b0);
                else if (pop_item.cls == CLS_STAR)
                    st = mk(PH_BBLOCK, 1'b0, 1'b0);
                else
                    st = bws(pop_item.cls);
            end
            PH_BLINE:
            begin
                if (pop_item.cls == CLS_ZERO || pop_item.cls == CLS_NEWLINE)
                    st = bws(pop_item.cls);
                else
                    st = mk(PH_BLINE, 1'b0, 1'b0);
            end
            PH_BBLOCK:
            begin
                st = bblock(pop_item.cls);
            end
            PH_BSTAR:
            begin
                if (pop_item.cls == CLS_SLASH)
                    st = mk(PH_BWS, 1'b0, 1'b0);
                else
                    st = bblock(pop_item.cls);
            end
            PH_BDISP:
            begin
                st = bdisp(pop_item.cls);
            end
            PH_BSTR:
            begin
                st = bstr(pop_item.cls);
            end
            PH_BESC:
            begin
                if (pop_item.cls == CLS_DQUOTE)
                    st = mk(PH_BSTR, 1'b0, 1'b0);
                else
                    st = bstr(pop_item.cls);
            end
            default:
            begin
                st = mk(PH_IDLE, 1'b1, 1'b1);
            end
        endcase
        phase_next = st.phase;
    end

    // Result register loading.
    always_comb
    begin
        emit           = pop_valid && take && st.done;
        emit_found     = st.found;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_found_next = out_found_reg;
        out_kind_next  = out_kind_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_found_next = emit_found;
            out_kind_next  = kind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= KIND_SEMI;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop_valid && take)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_kind_reg  <= out_kind_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, out_found_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

/* rtl/core/automatic_semicolon_and_block_scanner_top.sv */
// Scanner that decides whether a semicolon or an empty block is implied in source text.
// The slave channel carries one code point per beat; a beat with the start flag set opens
// a new scan, and its mode field selects a semicolon scan, a block scan or neither.
// Code point zero stands for the end of the input. Each scan ends in exactly one beat on
// the master channel, carrying the decision and the kind of token; a start beat asking for
// neither answers at once with a negative decision. A start beat during a running scan
// abandons that scan silently, and beats outside any scan are dropped.
// A beat is classified in the front end on acceptance and written into a four-entry queue;
// while the output register is free or read, the back end takes one queued beat per cycle
// through the scan state machine into that register. A deciding beat passes a queue slot
// and then the output register; with tready high one beat per cycle is sustained both ways.
// When the receiver stalls, the result is held in the output register and the queue keeps
// taking beats until it is full, at which point tready on the slave side drops.
// Reset returns the scan to idle, empties the queue and clears the output valid.
module automatic_semicolon_and_block_scanner_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [asbs_pkg::S_TDATA_W-1:0] s_axis_tdata,  // code_point, zero padding
    input  logic [asbs_pkg::S_TUSER_W-1:0] s_axis_tuser,  // start_req, mode, at_range_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [asbs_pkg::M_TDATA_W-1:0] m_axis_tdata,  // found, zero padding
    output logic                           m_axis_tuser   // token_kind
);
    import asbs_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    asbs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    asbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    asbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* rtl/core/asbs_checker.sv */
module asbs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [asbs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);
    import asbs_pkg::*;

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result beat withdrawn before it was taken.");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result beat changed while stalled.");

    a_padding_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:1] == '0)
        else $error("Padding bits of a result beat are not zero.");

    a_quiet_in_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("Result beat offered during reset.");

endmodule

bind automatic_semicolon_and_block_scanner_top asbs_checker u_asbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
